// ===== sv/alpha_map_stream_decoder_assert.svh =====
// ============================================================================
// alpha_map_stream_decoder_assert.svh
// Assertion macros of the alpha map decoder top module.
// ============================================================================
`ifndef ALPHA_MAP_STREAM_DECODER_ASSERT_SVH
`define ALPHA_MAP_STREAM_DECODER_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle
`define AMSD_ASSERT_IMP(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("alpha map decoder: same-cycle check failed");

// Check that a condition implies a consequence in the next cycle
`define AMSD_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("alpha map decoder: next-cycle check failed");

`endif

// ===== sv/amsd_pkg.sv =====
// ============================================================================
// amsd_pkg
// Types, constants and tables of the alpha map stream decoder.
// ============================================================================
`default_nettype none

package amsd_pkg;

    // Map geometry
    localparam int MAP_SIDE   = 64;
    localparam int MAP_PIXELS = MAP_SIDE * MAP_SIDE;
    localparam int PC_W       = $clog2(MAP_PIXELS + 1);
    localparam int COL_W      = $clog2(MAP_SIDE);

    // Start of the second-to-last and of the last row
    localparam int ROW_LAST2_START = (MAP_SIDE - 2) * MAP_SIDE;
    localparam int ROW_LAST_START  = (MAP_SIDE - 1) * MAP_SIDE;

    // Line buffer: two banks split by column parity
    localparam int BANK_DEPTH = (MAP_SIDE + 1) / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    // Field widths
    localparam int PIX_W   = 8;
    localparam int INDEX_W = 12;
    localparam int RUN_W   = 7;
    localparam int FMT_W   = 2;

    localparam int RUN_MAX = 127;

    // Column-plus-run sum and its wrap table
    localparam int SUM_W     = $clog2(MAP_SIDE + RUN_MAX);
    localparam int MOD_DEPTH = 2 ** SUM_W;

    // Format codes (code 3 decodes as raw)
    localparam logic [FMT_W-1:0] FMT_PACKED = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RAW    = 2'd1;
    localparam logic [FMT_W-1:0] FMT_RLE    = 2'd2;

    typedef logic [PC_W-1:0]    pcount_t;
    typedef logic [COL_W-1:0]   col_t;
    typedef logic [BANK_AW-1:0] bank_addr_t;
    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [RUN_W-1:0]   run_t;
    typedef logic [FMT_W-1:0]   fmt_t;

    // Run-length decoder phase
    typedef enum logic [2:0] {
        PH_CTRL = 3'b001,
        PH_FILL = 3'b010,
        PH_COPY = 3'b100
    } rle_phase_t;

    // One result waiting in the output stage
    typedef struct packed {
        pix_t                 value;
        logic [INDEX_W-1:0]   first_index;
        run_t                 run_length;
        logic                 last;
        logic                 done;
        logic                 use_ram;
        logic                 bank;
    } slot_t;

    // Line buffer request of one pixel
    typedef struct packed {
        logic       wr;
        logic       rd;
        logic       bank;
        bank_addr_t addr;
        pix_t       data;
    } lb_req_t;

    // Decoded request: results and line buffer accesses
    typedef struct packed {
        logic [1:0]          count;
        slot_t   [1:0]       slot;
        lb_req_t [1:0]       lb;
    } decode_t;

    typedef logic [MOD_DEPTH-1:0][COL_W-1:0] mod_table_t;

    // Column after a wrap: sum modulo the map side
    function automatic mod_table_t build_mod_table();
        mod_table_t t;
        for (int i = 0; i < MOD_DEPTH; i++)
        begin
            t[i] = COL_W'(i % MAP_SIDE);
        end
        return t;
    endfunction

    localparam mod_table_t MOD_TABLE = build_mod_table();

endpackage

`default_nettype wire

// ===== sv/amsd_ifs.sv =====
// ============================================================================
// amsd_ifs
// Valid/ready channels of the alpha map decoder: bytes, runs, format.
// ============================================================================
`default_nettype none

interface amsd_in_if;
    import amsd_pkg::*;
    logic valid;
    logic ready;
    pix_t data_byte;
    logic start_of_map;

    modport source (output valid, output data_byte, output start_of_map, input ready);
    modport sink   (input valid, input data_byte, input start_of_map, output ready);
endinterface

interface amsd_out_if;
    import amsd_pkg::*;
    logic               valid;
    logic               ready;
    pix_t               pixel_value;
    logic [INDEX_W-1:0] first_index;
    run_t               run_length;
    logic               last_of_item;
    logic               map_done;

    modport source (output valid, output pixel_value, output first_index,
                    output run_length, output last_of_item, output map_done,
                    input ready);
    modport sink   (input valid, input pixel_value, input first_index,
                    input run_length, input last_of_item, input map_done,
                    output ready);
endinterface

interface amsd_cfg_if;
    import amsd_pkg::*;
    logic valid;
    logic ready;
    fmt_t format;

    modport source (output valid, output format, input ready);
    modport sink   (input valid, input format, output ready);
endinterface

`default_nettype wire

// ===== sv/amsd_ram.sv =====
// ============================================================================
// amsd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
`default_nettype none

module amsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/amsd_decode.sv =====
// ============================================================================
// amsd_decode
// Decoder state and the per-byte decode into runs and line buffer accesses.
// ============================================================================
`default_nettype none

module amsd_decode (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire amsd_pkg::pix_t    data_byte,
    input  wire logic              start_of_map,
    input  wire amsd_pkg::fmt_t    format,
    output      amsd_pkg::decode_t dec
);
    import amsd_pkg::*;

    pcount_t    pc_reg, pc_next;
    col_t       col_reg, col_next;
    rle_phase_t phase_reg, phase_next;
    run_t       left_reg, left_next;

    pcount_t    pc_eff;
    col_t       col_eff;
    rle_phase_t phase_eff;
    run_t       left_eff;
    pcount_t    room;
    pcount_t    pc_one;
    col_t       col_one;
    run_t       fill_len;
    logic       packed_fmt;
    pix_t       pix0, pix1;
    logic       in_last2_0, in_last_0, in_last2_1, in_last_1;

    // Build one result slot
    function automatic slot_t make_slot(input pix_t v, input pcount_t first,
                                        input run_t len, input pcount_t space,
                                        input logic use_ram, input logic bank);
        slot_t s;
        s.value       = v;
        s.first_index = INDEX_W'(first);
        s.run_length  = len;
        s.last        = 1'b0;
        s.done        = (PC_W'(len) >= space);
        s.use_ram     = use_ram;
        s.bank        = bank;
        return s;
    endfunction

    // Advance a column by one
    function automatic col_t col_inc(input col_t c);
        return (c == COL_W'(MAP_SIDE - 1)) ? '0 : c + 1'b1;
    endfunction

    // Apply start of map ahead of the byte
    assign pc_eff    = start_of_map ? '0 : pc_reg;
    assign col_eff   = start_of_map ? '0 : col_reg;
    assign phase_eff = start_of_map ? PH_CTRL : phase_reg;
    assign left_eff  = start_of_map ? '0 : left_reg;

    assign room       = PC_W'(MAP_PIXELS) - pc_eff;
    assign pc_one     = pc_eff + 1'b1;
    assign col_one    = col_inc(col_eff);
    assign fill_len   = (PC_W'(left_eff) > room) ? RUN_W'(room) : left_eff;
    assign packed_fmt = (format == FMT_PACKED);

    // Pixel values of the uncompressed formats
    assign pix0 = packed_fmt ? {data_byte[3:0], data_byte[3:0]} : data_byte;
    assign pix1 = (col_one != COL_W'(MAP_SIDE - 1)) ? {data_byte[7:4], data_byte[7:4]}
                                                     : {data_byte[3:0], data_byte[3:0]};

    // Row position of the two pixels
    assign in_last2_0 = (pc_eff >= PC_W'(ROW_LAST2_START)) && (pc_eff < PC_W'(ROW_LAST_START));
    assign in_last_0  = (pc_eff >= PC_W'(ROW_LAST_START));
    assign in_last2_1 = (pc_one >= PC_W'(ROW_LAST2_START)) && (pc_one < PC_W'(ROW_LAST_START));
    assign in_last_1  = (pc_one >= PC_W'(ROW_LAST_START));

    // Decode one byte
    always_comb
    begin
        dec        = '0;
        pc_next    = pc_eff;
        col_next   = col_eff;
        phase_next = phase_eff;
        left_next  = left_eff;

        if (pc_eff < PC_W'(MAP_PIXELS))
        begin
            if (format == FMT_RLE)
            begin
                case (phase_eff)
                    PH_FILL:
                    begin
                        phase_next = PH_CTRL;
                        left_next  = '0;
                        if (left_eff != '0)
                        begin
                            dec.count   = 2'd1;
                            dec.slot[0] = make_slot(data_byte, pc_eff, fill_len, room,
                                                    1'b0, 1'b0);
                            dec.slot[0].last = 1'b1;
                            pc_next  = pc_eff + PC_W'(fill_len);
                            col_next = MOD_TABLE[SUM_W'(col_eff) + SUM_W'(fill_len)];
                        end
                    end
                    PH_COPY:
                    begin
                        dec.count   = 2'd1;
                        dec.slot[0] = make_slot(data_byte, pc_eff, RUN_W'(1), room,
                                                1'b0, 1'b0);
                        dec.slot[0].last = 1'b1;
                        pc_next   = pc_one;
                        col_next  = col_one;
                        left_next = left_eff - 1'b1;
                        if (left_eff == RUN_W'(1))
                        begin
                            phase_next = PH_CTRL;
                        end
                    end
                    default:
                    begin
                        // Control byte: fill flag and count
                        left_next = data_byte[6:0];
                        if (data_byte[7])
                        begin
                            phase_next = PH_FILL;
                        end
                        else if (data_byte[6:0] != '0)
                        begin
                            phase_next = PH_COPY;
                        end
                        else
                        begin
                            phase_next = PH_CTRL;
                        end
                    end
                endcase
            end
            else
            begin
                // First pixel of the byte
                dec.count   = 2'd1;
                dec.slot[0] = make_slot(pix0, pc_eff, RUN_W'(1), room, in_last_0,
                                        col_eff[0]);
                dec.lb[0].wr   = in_last2_0;
                dec.lb[0].rd   = in_last_0;
                dec.lb[0].bank = col_eff[0];
                dec.lb[0].addr = BANK_AW'(col_eff >> 1);
                dec.lb[0].data = pix0;
                pc_next  = pc_one;
                col_next = col_one;

                // Second pixel in packed format, unless the map ends
                if (packed_fmt && (pc_one < PC_W'(MAP_PIXELS)))
                begin
                    dec.count   = 2'd2;
                    dec.slot[1] = make_slot(pix1, pc_one, RUN_W'(1), room - 1'b1,
                                            in_last_1, col_one[0]);
                    dec.slot[1].last = 1'b1;
                    dec.lb[1].wr   = in_last2_1;
                    dec.lb[1].rd   = in_last_1;
                    dec.lb[1].bank = col_one[0];
                    dec.lb[1].addr = BANK_AW'(col_one >> 1);
                    dec.lb[1].data = pix1;
                    pc_next  = pc_one + 1'b1;
                    col_next = col_inc(col_one);
                end
                else
                begin
                    dec.slot[0].last = 1'b1;
                end
            end
        end
    end

    // Advance decoder state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= '0;
            col_reg   <= '0;
            phase_reg <= PH_CTRL;
            left_reg  <= '0;
        end
        else if (accept)
        begin
            pc_reg    <= pc_next;
            col_reg   <= col_next;
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/alpha_map_stream_decoder.sv =====
// ============================================================================
// alpha_map_stream_decoder
// Decodes packed, raw or run-length alpha bytes into runs of a square map.
// ============================================================================
//
//  channel        role    payload
//  -------------  ------  ------------------------------------------------
//  alpha_stream   sink    data_byte, start_of_map
//  run_stream     source  pixel_value, first_index, run_length,
//                         last_of_item, map_done
//  cfg            sink    format (always ready)
//
//  A result appears in the cycle after its byte is accepted; the output stage
//  register also absorbs the line buffer read latency.
//  Raw and run-length formats take one byte per cycle while the run channel
//  does not stall; packed gives two runs per byte, handed out one per request.
//  A new byte is taken while the last run of the previous byte is handed out.
//  Reset clears the decoder state and the format; the line buffer needs none.
//
`default_nettype none

`include "alpha_map_stream_decoder_assert.svh"

module alpha_map_stream_decoder (
    input  wire logic  clk,
    input  wire logic  rst_n,
    amsd_in_if.sink    alpha_stream,
    amsd_out_if.source run_stream,
    amsd_cfg_if.sink   cfg
);
    import amsd_pkg::*;

    fmt_t       format_reg;
    decode_t    dec;
    slot_t [1:0] slot_reg;
    logic [1:0] cnt_reg;
    logic       pos_reg;

    slot_t      cur_slot;
    logic       in_fire;
    logic       out_fire;
    logic       drain_last;

    logic [1:0] bank_we;
    logic [1:0] bank_re;
    bank_addr_t bank_waddr [2];
    bank_addr_t bank_raddr [2];
    pix_t       bank_wdata [2];
    pix_t       bank_rdata [2];

    // Format register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FMT_PACKED;
        end
        else if (cfg.valid)
        begin
            format_reg <= cfg.format;
        end
    end

    // Handshakes
    assign cur_slot   = slot_reg[pos_reg];
    assign out_fire   = run_stream.valid && run_stream.ready;
    assign drain_last = out_fire && cur_slot.last;
    assign alpha_stream.ready = (cnt_reg == 2'd0) || drain_last;
    assign in_fire    = alpha_stream.valid && alpha_stream.ready;

    amsd_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_fire),
        .data_byte    (alpha_stream.data_byte),
        .start_of_map (alpha_stream.start_of_map),
        .format       (format_reg),
        .dec          (dec)
    );

    // Line buffer banks, split by column parity
    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        logic hit_w0, hit_w1, hit_r0, hit_r1;

        assign hit_w0 = dec.lb[0].wr && (dec.lb[0].bank == 1'(b));
        assign hit_w1 = dec.lb[1].wr && (dec.lb[1].bank == 1'(b));
        assign hit_r0 = dec.lb[0].rd && (dec.lb[0].bank == 1'(b));
        assign hit_r1 = dec.lb[1].rd && (dec.lb[1].bank == 1'(b));

        assign bank_we[b]    = in_fire && (hit_w0 || hit_w1);
        assign bank_waddr[b] = hit_w0 ? dec.lb[0].addr : dec.lb[1].addr;
        assign bank_wdata[b] = hit_w0 ? dec.lb[0].data : dec.lb[1].data;
        assign bank_re[b]    = in_fire && (hit_r0 || hit_r1);
        assign bank_raddr[b] = hit_r0 ? dec.lb[0].addr : dec.lb[1].addr;

        amsd_ram #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (bank_waddr[b]),
            .wdata (bank_wdata[b]),
            .re    (bank_re[b]),
            .raddr (bank_raddr[b]),
            .rdata (bank_rdata[b])
        );
    end

    // Output stage: load the runs of a byte, hand them out in order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            pos_reg <= 1'b0;
        end
        else if (in_fire && (dec.count != 2'd0))
        begin
            cnt_reg <= dec.count;
            pos_reg <= 1'b0;
        end
        else if (drain_last)
        begin
            cnt_reg <= 2'd0;
            pos_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            pos_reg <= 1'b1;
        end
    end

    // Hold the run payload
    always_ff @(posedge clk)
    begin
        if (in_fire && (dec.count != 2'd0))
        begin
            slot_reg <= dec.slot;
        end
    end

    // Drive the run channel
    assign run_stream.valid        = (cnt_reg != 2'd0);
    assign run_stream.pixel_value  = cur_slot.use_ram ? bank_rdata[cur_slot.bank]
                                                      : cur_slot.value;
    assign run_stream.first_index  = cur_slot.first_index;
    assign run_stream.run_length   = cur_slot.run_length;
    assign run_stream.last_of_item = cur_slot.last;
    assign run_stream.map_done     = cur_slot.done;

    // Checks
    `AMSD_ASSERT_IMP(a_done_is_last, clk, rst_n, run_stream.valid && run_stream.map_done, run_stream.last_of_item)
    `AMSD_ASSERT_IMP(a_run_nonzero, clk, rst_n, run_stream.valid, run_stream.run_length != '0)
    `AMSD_ASSERT_IMP(a_accept_drained, clk, rst_n, in_fire && (cnt_reg != 2'd0), drain_last)
    `AMSD_ASSERT_IMP(a_one_write_per_bank, clk, rst_n, in_fire && dec.lb[0].wr && dec.lb[1].wr, dec.lb[0].bank != dec.lb[1].bank)
    `AMSD_ASSERT_IMP(a_one_read_per_bank, clk, rst_n, in_fire && dec.lb[0].rd && dec.lb[1].rd, dec.lb[0].bank != dec.lb[1].bank)
    `AMSD_ASSERT_NEXT(a_second_run_follows, clk, rst_n, out_fire && !cur_slot.last, run_stream.valid && pos_reg)

endmodule

`default_nettype wire

// ===== bench/alpha_map_stream_decoder_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// alpha_map_stream_decoder_checker
// Watches the byte, run and format channels of the alpha map decoder, works
// out the runs that each accepted byte must give and compares every accepted
// run with the oldest one still waiting.
// ============================================================================

module alpha_map_stream_decoder_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    amsd_in_if        in_ch,
    amsd_out_if       out_ch,
    amsd_cfg_if       cfg_ch,
    output int        fail_count,
    output int        runs_pending,
    output int        runs_seen
);
    import amsd_pkg::*;

    // One decoded run as it must appear on the run channel
    typedef struct packed {
        pix_t               value;
        logic [INDEX_W-1:0] first_index;
        run_t               run_length;
        logic               last;
        logic               done;
    } run_rec_t;

    // Decoder state as the byte stream leaves it
    fmt_t       cur_format;
    pcount_t    pix_count;
    rle_phase_t phase;
    run_t       run_left;
    pix_t       row_buf [MAP_SIDE];

    run_rec_t   pending_runs [$];

    // Build one run; done marks a run that reaches the last pixel
    function automatic run_rec_t make_run(input pix_t v, input pcount_t at,
                                          input int unsigned n);
        run_rec_t r;
        r.value       = v;
        r.first_index = at[INDEX_W-1:0];
        r.run_length  = run_t'(n);
        r.last        = 1'b0;
        r.done        = (int'(at) + n >= MAP_PIXELS);
        return r;
    endfunction

    // Decode one byte request and queue the runs it gives
    task automatic decode_byte(input pix_t b, input logic som);
        run_rec_t    recs [2];
        int          n;
        int          k;
        int          ppb;
        int unsigned len;
        int unsigned col;
        int unsigned row;
        pix_t        v;
        logic [3:0]  nib;
        n = 0;
        if (som)
        begin
            pix_count = '0;
            phase     = PH_CTRL;
            run_left  = '0;
        end
        if (pix_count < MAP_PIXELS)
        begin
            if (cur_format == FMT_RLE)
            begin
                case (phase)
                    PH_FILL:
                    begin
                        len      = run_left;
                        phase    = PH_CTRL;
                        run_left = '0;
                        if (len != 0)
                        begin
                            // clip the fill at the end of the map
                            if (len > MAP_PIXELS - pix_count)
                                len = MAP_PIXELS - pix_count;
                            recs[0]   = make_run(b, pix_count, len);
                            pix_count = pcount_t'(pix_count + len);
                            n         = 1;
                        end
                    end
                    PH_COPY:
                    begin
                        recs[0]   = make_run(b, pix_count, 1);
                        pix_count = pcount_t'(pix_count + 1);
                        run_left  = run_left - 1'b1;
                        if (run_left == 0)
                            phase = PH_CTRL;
                        n = 1;
                    end
                    default:
                    begin
                        // control byte: fill flag and count, no run yet
                        run_left = b[6:0];
                        if (b[7])
                            phase = PH_FILL;
                        else if (b[6:0] != 0)
                            phase = PH_COPY;
                        else
                            phase = PH_CTRL;
                    end
                endcase
            end
            else
            begin
                ppb = (cur_format == FMT_PACKED) ? 2 : 1;
                k   = 0;
                while (k < ppb && pix_count < MAP_PIXELS)
                begin
                    col = pix_count % MAP_SIDE;
                    row = pix_count / MAP_SIDE;
                    if (cur_format == FMT_PACKED)
                    begin
                        // last column always takes the low nibble
                        nib = (k == 1 && col != MAP_SIDE - 1) ? b[7:4] : b[3:0];
                        v   = pix_t'(nib * 17);
                    end
                    else
                    begin
                        v = b;
                    end
                    // hold row 62, replay it on row 63
                    if (row == MAP_SIDE - 2)
                        row_buf[col] = v;
                    if (row == MAP_SIDE - 1)
                        v = row_buf[col];
                    recs[n]   = make_run(v, pix_count, 1);
                    pix_count = pcount_t'(pix_count + 1);
                    n++;
                    k++;
                end
            end
        end
        if (n > 0)
            recs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            pending_runs.push_back(recs[i]);
        end
    endtask

    // Track format writes and byte requests, check each run request
    always @(posedge clk or negedge rst_n)
    begin
        run_rec_t want;
        run_rec_t got;
        if (!rst_n)
        begin
            cur_format = FMT_PACKED;
            pix_count  = '0;
            phase      = PH_CTRL;
            run_left   = '0;
            pending_runs.delete();
            fail_count   = 0;
            runs_pending = 0;
            runs_seen    = 0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                cur_format = cfg_ch.format;
            if (in_ch.valid && in_ch.ready)
                decode_byte(in_ch.data_byte, in_ch.start_of_map);
            if (out_ch.valid && out_ch.ready)
            begin
                got.value       = out_ch.pixel_value;
                got.first_index = out_ch.first_index;
                got.run_length  = out_ch.run_length;
                got.last        = out_ch.last_of_item;
                got.done        = out_ch.map_done;
                runs_seen++;
                if (pending_runs.size() == 0)
                begin
                    $display("%0t: run with none pending: value %0d index %0d length %0d last %0b done %0b",
                             $time, got.value, got.first_index, got.run_length,
                             got.last, got.done);
                    fail_count++;
                end
                else
                begin
                    want = pending_runs.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: run mismatch: expected value %0d index %0d length %0d last %0b done %0b",
                                 $time, want.value, want.first_index, want.run_length,
                                 want.last, want.done);
                        $display("%0t:                 actual value %0d index %0d length %0d last %0b done %0b",
                                 $time, got.value, got.first_index, got.run_length,
                                 got.last, got.done);
                        fail_count++;
                    end
                end
            end
            runs_pending = pending_runs.size();
        end
    end

endmodule

// ===== bench/alpha_map_stream_decoder_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// alpha_map_stream_decoder_tb
// Drives encoded alpha bytes into the decoder in all format codes, with
// run-length prefixes that carry some maps close to their last two rows so the
// line buffer replay is reached, and leaves checking to the checker module.
// ============================================================================

module alpha_map_stream_decoder_tb;
    import amsd_pkg::*;

    localparam int   QUIET_LIMIT  = 1000;
    localparam int   DRAIN_CYCLES = 8;
    // a phase ends only after its current map, so it runs past this goal
    localparam int   PHASE_ITEMS  = 200;
    // unused code, decodes as raw
    localparam fmt_t FMT_RAW_ALT  = 2'd3;

    logic clk;
    logic rst_n;

    int tx_idle_pct;
    int rx_idle_pct;
    int bytes_sent;
    int maps_started;
    int quiet_cycles;
    int fail_count;
    int runs_pending;
    int runs_seen;

    amsd_in_if  alpha_stream ();
    amsd_out_if run_stream ();
    amsd_cfg_if cfg ();

    alpha_map_stream_decoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .alpha_stream (alpha_stream),
        .run_stream   (run_stream),
        .cfg          (cfg)
    );

    alpha_map_stream_decoder_checker run_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (alpha_stream),
        .out_ch       (run_stream),
        .cfg_ch       (cfg),
        .fail_count   (fail_count),
        .runs_pending (runs_pending),
        .runs_seen    (runs_seen)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Stall the run channel at random
    always @(negedge clk)
    begin
        run_stream.ready = ($urandom_range(99) >= rx_idle_pct);
    end

    // End the run when no request moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((alpha_stream.valid && alpha_stream.ready) ||
                (run_stream.valid && run_stream.ready) ||
                (cfg.valid && cfg.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t: no request accepted for %0d cycles", $time, quiet_cycles);
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    // Offer one byte request, with a random gap first
    task automatic send_byte(input pix_t b, input logic som);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            alpha_stream.valid = 1'b0;
            @(negedge clk);
        end
        alpha_stream.valid        = 1'b1;
        alpha_stream.data_byte    = b;
        alpha_stream.start_of_map = som;
        @(posedge clk);
        while (!alpha_stream.ready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Drop the byte channel, drain the decoder, then write the format
    task automatic set_format(input fmt_t f);
        alpha_stream.valid = 1'b0;
        while (runs_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg.valid  = 1'b1;
        cfg.format = f;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // Start a map in run-length format and advance it to the target pixel;
    // with clip_end the final fill may run past the end of the map
    task automatic rle_to(input int unsigned target, input bit clip_end);
        int unsigned pc;
        int unsigned rem;
        int unsigned n;
        int unsigned pick;
        logic        som;
        pc  = 0;
        som = 1'b1;
        while (pc < target)
        begin
            rem  = target - pc;
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                // empty fill: the fill byte is still consumed
                send_byte(8'h80, som);
                send_byte(pix_t'($urandom_range(255)), 1'b0);
            end
            else if (pick < 8)
            begin
                // empty copy
                send_byte(8'h00, som);
            end
            else if (pick < 30)
            begin
                n = $urandom_range(6, 1);
                if (n > rem)
                    n = rem;
                send_byte(pix_t'(n), som);
                repeat (n) send_byte(pix_t'($urandom_range(255)), 1'b0);
                pc += n;
            end
            else
            begin
                n = $urandom_range(RUN_MAX, 32);
                if (clip_end && rem <= RUN_MAX)
                    n = $urandom_range(RUN_MAX, rem);
                else if (n > rem)
                    n = rem;
                send_byte(8'h80 | pix_t'(n), som);
                send_byte(pix_t'($urandom_range(255)), 1'b0);
                pc += n;
            end
            som = 1'b0;
        end
    endtask

    // One random map: a full map with the line buffer in use, a full
    // run-length map, or a short burst of noise
    task automatic run_map();
        int unsigned kind;
        int unsigned target;
        int unsigned tail;
        int unsigned nbytes;
        fmt_t        tail_fmt;
        fmt_t        noise_fmt;
        kind = $urandom_range(99);
        maps_started++;
        if (kind < 55)
        begin
            // stop the prefix at or before row 62 so the whole row is buffered
            target = $urandom_range(ROW_LAST2_START, ROW_LAST2_START - 100);
            set_format(FMT_RLE);
            rle_to(target, 1'b0);
            case ($urandom_range(2))
                0:       tail_fmt = FMT_PACKED;
                1:       tail_fmt = FMT_RAW;
                default: tail_fmt = FMT_RAW_ALT;
            endcase
            set_format(tail_fmt);
            tail = (tail_fmt == FMT_PACKED) ? (MAP_PIXELS - target + 1) / 2
                                            : MAP_PIXELS - target;
            repeat (tail) send_byte(pix_t'($urandom_range(255)), 1'b0);
            // bytes past the map end give nothing
            repeat ($urandom_range(2)) send_byte(pix_t'($urandom_range(255)), 1'b0);
        end
        else if (kind < 75)
        begin
            set_format(FMT_RLE);
            rle_to(MAP_PIXELS, 1'b1);
            repeat ($urandom_range(3)) send_byte(pix_t'($urandom_range(255)), 1'b0);
        end
        else
        begin
            noise_fmt = fmt_t'($urandom_range(3));
            set_format(noise_fmt);
            nbytes = $urandom_range(30, 12);
            send_byte(pix_t'($urandom_range(255)), 1'b1);
            repeat (nbytes)
                send_byte(pix_t'($urandom_range(255)), ($urandom_range(9) == 0));
        end
    endtask

    // Run a block of random maps under one idle setting
    task automatic random_phase(input int tx_pct, input int rx_pct);
        int goal;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        goal        = bytes_sent + PHASE_ITEMS;
        while (bytes_sent < goal)
            run_map();
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n                     = 1'b0;
        alpha_stream.valid        = 1'b0;
        alpha_stream.data_byte    = '0;
        alpha_stream.start_of_map = 1'b0;
        run_stream.ready          = 1'b0;
        cfg.valid                 = 1'b0;
        cfg.format                = FMT_PACKED;
        tx_idle_pct               = 16;
        rx_idle_pct               = 74;
        bytes_sent                = 0;
        maps_started              = 0;
        quiet_cycles              = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Packed format from reset: nibble extremes
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b0);

        // Raw format and the unused code
        set_format(FMT_RAW);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        set_format(FMT_RAW_ALT);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h80, 1'b0);

        // Run-length: empty fill, empty copy, fill, copy, longest fill
        set_format(FMT_RLE);
        send_byte(8'h80, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h83, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        // new map in the middle of a copy run
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h81, 1'b1);
        send_byte(8'h12, 1'b0);
        // format change while a fill is pending keeps the pending fill
        send_byte(8'h84, 1'b0);
        set_format(FMT_RAW);
        send_byte(8'h33, 1'b0);
        set_format(FMT_RLE);
        send_byte(8'h44, 1'b0);

        // Random maps under each idle setting
        random_phase(16, 74);
        random_phase(74, 16);
        random_phase(0, 0);

        // Drain and let the pipeline settle
        alpha_stream.valid = 1'b0;
        while (runs_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Decoded %0d bytes over %0d random maps plus directed cases,", bytes_sent,
                 maps_started);
        $display("in packed, raw and run-length formats; %0d runs compared.", runs_seen);
        if (fail_count == 0 && runs_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/amsd_pkg.sv
sv/amsd_ifs.sv
sv/amsd_ram.sv
sv/amsd_decode.sv
sv/alpha_map_stream_decoder.sv
bench/alpha_map_stream_decoder_checker.sv
bench/alpha_map_stream_decoder_tb.sv
